@@ hdl/swrm_pkg.sv @@
// Shared types, constants and helper functions for the RF power and SWR meter.
// Used by the result interface, the controller, the datapath and the top level.
// No dependencies.
`default_nettype none

package swrm_pkg;

  // Result field widths and limits.
  localparam int unsigned PWR_W = 18;
  localparam int unsigned SWR_W = 17;
  localparam logic [PWR_W-1:0] PWR_MAX = 18'd262143;
  localparam logic [SWR_W-1:0] SWR_ONE = 17'd1024;
  localparam logic [SWR_W-1:0] SWR_MAX = 17'd102297;

  // Forward sample clamp in Q12.4 (1 to 2257).
  localparam logic [15:0] FWD_MIN = 16'd16;
  localparam logic [15:0] FWD_MAX = 16'd36112;

  // Reciprocal of 1000 scaled by 2^36, exact for every operand below 2^26.
  localparam logic [26:0] RECIP_1000 = 27'd68719477;

  // 50000 / 16: the power constant with its factor of sixteen folded into the shift.
  localparam logic [11:0] PWR_K = 12'd3125;

  // Current above which the power saturates.
  localparam logic [24:0] CUR_LIMIT = 25'd4194304;

  // Quotient bits produced by the SWR divider.
  localparam int unsigned QBITS = 18;
  localparam int unsigned QCNT_W = $clog2(QBITS);

  // RF-off tick counter values.
  localparam logic [13:0] OFF_PRESENT = 14'd1000;
  localparam logic [13:0] OFF_PARK = 14'd12000;
  localparam logic [13:0] OFF_SAT = 14'd16383;

  // Configuration port.
  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned CFG_DATA_W = 18;
  localparam logic [CFG_IDX_W-1:0] CFG_ADC_SCALE = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_COUPLER_GAIN = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_DIODE_DROP_CAP = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_DETECT_THRESHOLD = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_CHANGE_THRESHOLD = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_AVG_ALPHA = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_OFF_TIMEOUT = 3'd6;

  typedef struct packed {
    logic [15:0] adc_scale;
    logic [15:0] coupler_gain;
    logic [9:0]  diode_drop_cap;
    logic [17:0] detect_threshold_mw;
    logic [9:0]  change_threshold;
    logic [15:0] avg_alpha;
    logic [13:0] off_timeout;
  } cfg_t;

  // Sequencer steps issued by the controller to the datapath.
  typedef logic [4:0] step_t;
  localparam step_t ST_NOP  = 5'd0;
  localparam step_t ST_SCF  = 5'd1;
  localparam step_t ST_SCR  = 5'd2;
  localparam step_t ST_SCR2 = 5'd3;
  localparam step_t ST_DROP = 5'd4;
  localparam step_t ST_U    = 5'd5;
  localparam step_t ST_TURN = 5'd6;
  localparam step_t ST_A    = 5'd7;
  localparam step_t ST_SQ   = 5'd8;
  localparam step_t ST_LO   = 5'd9;
  localparam step_t ST_HI   = 5'd10;
  localparam step_t ST_PWR  = 5'd11;
  localparam step_t ST_SINIT = 5'd12;
  localparam step_t ST_SCHK = 5'd13;
  localparam step_t ST_SDIV = 5'd14;
  localparam step_t ST_SFIN = 5'd15;
  localparam step_t ST_HCTL = 5'd16;
  localparam step_t ST_B1   = 5'd17;
  localparam step_t ST_B2   = 5'd18;
  localparam step_t ST_B3   = 5'd19;
  localparam step_t ST_B4   = 5'd20;
  localparam step_t ST_B5   = 5'd21;
  localparam step_t ST_B6   = 5'd22;
  localparam step_t ST_B7   = 5'd23;
  localparam step_t ST_OUT  = 5'd24;

  typedef struct packed {
    step_t step;
    logic  ch;
    logic  load_in;
  } cmd_t;

  typedef struct packed {
    logic swr_skip;
    logic out_full;
  } sts_t;

  typedef struct packed {
    logic [PWR_W-1:0] fwd_power;
    logic [PWR_W-1:0] rev_power;
    logic [SWR_W-1:0] swr_now;
    logic [PWR_W-1:0] peak_fwd;
    logic [PWR_W-1:0] peak_rev;
    logic [SWR_W-1:0] peak_swr;
    logic [PWR_W-1:0] mean_fwd;
    logic [PWR_W-1:0] mean_rev;
    logic [SWR_W-1:0] mean_swr;
    logic             rf_present;
  } res_t;

  // Floor division by 1023 of a 25-bit value, using 1024 = 1023 + 1 twice.
  function automatic logic [15:0] div1023(input logic [24:0] x);
    logic [15:0] t;
    logic [10:0] u;
    t = {1'b0, x[24:10]} + {6'd0, x[9:0]};
    u = {5'd0, t[15:10]} + {1'b0, t[9:0]};
    return {1'b0, x[24:10]} + {10'd0, t[15:10]} + {15'd0, (u >= 11'd1023)};
  endfunction

endpackage

`default_nettype wire

@@ hdl/swrm_in_if.sv @@
// Sample channel: valid/ready handshake carrying one forward and one reverse reading.
// Stands alone; the sample width follows ADC_BITS.
`default_nettype none

interface swrm_in_if #(
  parameter int unsigned ADC_BITS = 10
);
  logic                valid;
  logic                ready;
  logic [ADC_BITS-1:0] fwd_sample;
  logic [ADC_BITS-1:0] rev_sample;

  modport source (output valid, output fwd_sample, output rev_sample, input ready);
  modport sink   (input valid, input fwd_sample, input rev_sample, output ready);
endinterface

`default_nettype wire

@@ hdl/swrm_out_if.sv @@
// Result channel: valid/ready handshake carrying powers, SWR, peaks and averages.
// Depends on swrm_pkg for the field widths.
`default_nettype none

interface swrm_out_if import swrm_pkg::*;;
  logic             valid;
  logic             ready;
  logic [PWR_W-1:0] fwd_power;
  logic [PWR_W-1:0] rev_power;
  logic [SWR_W-1:0] swr_now;
  logic [PWR_W-1:0] peak_fwd;
  logic [PWR_W-1:0] peak_rev;
  logic [SWR_W-1:0] peak_swr;
  logic [PWR_W-1:0] mean_fwd;
  logic [PWR_W-1:0] mean_rev;
  logic [SWR_W-1:0] mean_swr;
  logic             rf_present;

  modport source (output valid, output fwd_power, output rev_power, output swr_now,
                  output peak_fwd, output peak_rev, output peak_swr, output mean_fwd,
                  output mean_rev, output mean_swr, output rf_present, input ready);
  modport sink   (input valid, input fwd_power, input rev_power, input swr_now,
                  input peak_fwd, input peak_rev, input peak_swr, input mean_fwd,
                  input mean_rev, input mean_swr, input rf_present, output ready);
endinterface

`default_nettype wire

@@ hdl/swrm_ctrl.sv @@
// Sequencer for the meter: walks the datapath through its steps for one request.
// Depends on swrm_pkg for step codes and the command and status structs.
`default_nettype none

module swrm_ctrl import swrm_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_ready_o,
  output cmd_t cmd_o,
  input  sts_t sts_i
);

  localparam logic CS_IDLE = 1'b0;
  localparam logic CS_RUN  = 1'b1;

  logic              state_q, state_d;
  step_t             step_q, step_d;
  logic              ch_q, ch_d;
  logic [QCNT_W-1:0] cnt_q, cnt_d;

  assign in_ready_o    = (state_q == CS_IDLE);
  assign cmd_o.load_in = in_ready_o & in_valid_i;
  assign cmd_o.step    = (state_q == CS_RUN) ? step_q : ST_NOP;
  assign cmd_o.ch      = ch_q;

  always_comb begin
    state_d = state_q;
    step_d  = step_q;
    ch_d    = ch_q;
    cnt_d   = cnt_q;
    case (state_q)
      CS_IDLE: begin
        if (in_valid_i) begin
          state_d = CS_RUN;
          step_d  = ST_SCF;
          ch_d    = 1'b0;
        end
      end
      CS_RUN: begin
        case (step_q)
          ST_SCF:  step_d = ST_SCR;
          ST_SCR:  step_d = ST_SCR2;
          ST_SCR2: step_d = ST_DROP;
          ST_DROP: step_d = ST_U;
          ST_U:    step_d = ST_TURN;
          ST_TURN: step_d = ST_A;
          ST_A:    step_d = ST_SQ;
          ST_SQ:   step_d = ST_LO;
          ST_LO:   step_d = ST_HI;
          ST_HI:   step_d = ST_PWR;
          ST_PWR: begin
            if (!ch_q) begin
              ch_d   = 1'b1;
              step_d = ST_DROP;
            end else begin
              step_d = ST_SINIT;
            end
          end
          ST_SINIT: step_d = ST_SCHK;
          ST_SCHK: begin
            step_d = ST_SDIV;
            cnt_d  = '0;
          end
          ST_SDIV: begin
            if (sts_i.swr_skip || (cnt_q == QCNT_W'(QBITS - 1))) begin
              step_d = ST_SFIN;
            end else begin
              cnt_d = cnt_q + 1'b1;
            end
          end
          ST_SFIN: step_d = ST_HCTL;
          ST_HCTL: step_d = ST_B1;
          ST_B1:   step_d = ST_B2;
          ST_B2:   step_d = ST_B3;
          ST_B3:   step_d = ST_B4;
          ST_B4:   step_d = ST_B5;
          ST_B5:   step_d = ST_B6;
          ST_B6:   step_d = ST_B7;
          ST_B7:   step_d = ST_OUT;
          ST_OUT: begin
            if (!sts_i.out_full) begin
              state_d = CS_IDLE;
            end
          end
          default: state_d = CS_IDLE;
        endcase
      end
      default: state_d = CS_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= CS_IDLE;
      step_q  <= ST_NOP;
      ch_q    <= 1'b0;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      step_q  <= step_d;
      ch_q    <= ch_d;
      cnt_q   <= cnt_d;
    end
  end

endmodule

`default_nettype wire

@@ hdl/swrm_dp.sv @@
// Datapath of the meter: one shared registered multiplier, a restoring SWR divider,
// the history registers and the output register. Depends on swrm_pkg.
`default_nettype none

module swrm_dp import swrm_pkg::*; #(
  parameter int unsigned ADC_BITS = 10
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  cfg_t                cfg_i,
  input  cmd_t                cmd_i,
  output sts_t                sts_o,
  input  logic [ADC_BITS-1:0] fwd_sample_i,
  input  logic [ADC_BITS-1:0] rev_sample_i,
  input  logic                out_ready_i,
  output logic                out_valid_o,
  output res_t                res_o
);

  // Working registers.
  logic [15:0]      raw_f_q, raw_r_q, sf_q, sr_q;
  logic [24:0]      base_q, u_q, a_q, af_q, ar_q;
  logic             big_q;
  logic [20:0]      sqhi_q;
  logic [35:0]      tmp_q;
  logic [53:0]      prod_q;
  logic [PWR_W-1:0] pf_q, pr_q;
  logic [36:0]      rem_q;
  logic [41:0]      dsr_q;
  logic [QBITS-1:0] quo_q;
  logic             skip_q, pres_q, mv_q;
  logic [SWR_W-1:0] swr_q;
  res_t             res_q;
  logic             out_vld_q;

  // History.
  logic [PWR_W-1:0] hold_f_q, hold_r_q, acc_f_q, acc_r_q;
  logic [SWR_W-1:0] hold_s_q, acc_s_q;
  logic [15:0]      prev_f_q, prev_r_q;
  logic [13:0]      off_q;

  logic [26:0] mul_a, mul_b;
  logic [15:0] s_cur;
  logic [32:0] sc_rnd;
  logic [15:0] sc_sat, sf_clamp;
  logic [24:0] x320, base_d;
  logic [25:0] y_drop;
  logic [22:0] drop_raw, drop_c;
  logic [41:0] a_rnd;
  logic [56:0] pwr_sum;
  logic [20:0] pwr_full;
  logic [PWR_W-1:0] pwr_d;
  logic [24:0] dif;
  logic [25:0] sum_af;
  logic [36:0] num;
  logic [16:0] na;
  logic [36:0] bsum;
  logic        pres_d, clr, moved;
  logic [15:0] df, dr;
  logic [SWR_W-1:0] quo_c;
  logic [13:0] off_step;
  logic        load_out;

  assign s_cur = cmd_i.ch ? sr_q : sf_q;

  // Scaling: round by 64, saturate to 16 bits.
  assign sc_rnd = {1'b0, prod_q[31:0]} + 33'd32;
  assign sc_sat = (|sc_rnd[32:22]) ? 16'hFFFF : sc_rnd[21:6];
  assign sf_clamp = (sc_sat < FWD_MIN) ? FWD_MIN : ((sc_sat > FWD_MAX) ? FWD_MAX : sc_sat);

  // Detector voltage in Q.20: base = s*5*65536/1023 = 320s + (320s+511)/1023.
  assign x320   = {1'b0, s_cur, 8'd0} + {3'd0, s_cur, 6'd0};
  assign base_d = x320 + {9'd0, div1023(x320 + 25'd511)};
  // Diode drop s*65536/1000 = 65s + (536s+500)/1000.
  assign y_drop = {1'b0, s_cur, 9'd0} + {6'd0, s_cur, 4'd0} + {7'd0, s_cur, 3'd0} + 26'd500;
  assign drop_raw = {1'b0, s_cur, 6'd0} + {7'd0, s_cur} + {6'd0, prod_q[52:36]};
  assign drop_c = (drop_raw > {3'd0, cfg_i.diode_drop_cap, 10'd0}) ?
                  {3'd0, cfg_i.diode_drop_cap, 10'd0} : drop_raw;

  assign a_rnd = {1'b0, prod_q[40:0]} + 42'd32768;

  // Power: (a*a*3125 + 2^35) >> 36, a*a*3125 assembled from two partial products.
  assign pwr_sum  = {prod_q[32:0], 24'd0} + {21'd0, tmp_q} + {22'd1, 35'd0};
  assign pwr_full = pwr_sum[56:36];
  assign pwr_d    = (big_q || (pwr_full > {3'd0, PWR_MAX})) ? PWR_MAX : pwr_full[PWR_W-1:0];

  assign dif    = af_q - ar_q;
  assign sum_af = {1'b0, af_q} + {1'b0, ar_q};
  assign num    = {1'b0, sum_af, 10'd0} + {13'd0, dif[24:1]};

  assign quo_c = (quo_q < {1'b0, SWR_ONE}) ? SWR_ONE :
                 ((quo_q > {1'b0, SWR_MAX}) ? SWR_MAX : quo_q[SWR_W-1:0]);

  assign na   = 17'd65536 - {1'b0, cfg_i.avg_alpha};
  assign bsum = {1'b0, tmp_q} + {1'b0, prod_q[35:0]} + 37'd32768;

  assign pres_d = pf_q > cfg_i.detect_threshold_mw;
  assign clr    = pres_d && (off_q > cfg_i.off_timeout);
  assign df     = (sf_q > prev_f_q) ? (sf_q - prev_f_q) : (prev_f_q - sf_q);
  assign dr     = (sr_q > prev_r_q) ? (sr_q - prev_r_q) : (prev_r_q - sr_q);
  assign moved  = (df > {6'd0, cfg_i.change_threshold}) ||
                  (dr > {6'd0, cfg_i.change_threshold});
  assign off_step = pres_d ? OFF_PRESENT : ((off_q < OFF_SAT) ? (off_q + 14'd1) : off_q);

  assign sts_o.out_full = out_vld_q & ~out_ready_i;
  assign sts_o.swr_skip = skip_q;
  assign load_out = (cmd_i.step == ST_OUT) && !sts_o.out_full;

  // Multiplier operand selection.
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (cmd_i.step)
      ST_SCF: begin
        mul_a = {11'd0, raw_f_q};
        mul_b = {11'd0, cfg_i.adc_scale};
      end
      ST_SCR: begin
        mul_a = {11'd0, raw_r_q};
        mul_b = {11'd0, cfg_i.adc_scale};
      end
      ST_DROP: begin
        mul_a = {1'b0, y_drop};
        mul_b = RECIP_1000;
      end
      ST_TURN: begin
        mul_a = {2'd0, u_q};
        mul_b = {11'd0, cfg_i.coupler_gain};
      end
      ST_SQ: begin
        mul_a = {4'd0, a_q[22:0]};
        mul_b = {4'd0, a_q[22:0]};
      end
      ST_LO: begin
        mul_a = {3'd0, prod_q[23:0]};
        mul_b = {15'd0, PWR_K};
      end
      ST_HI: begin
        mul_a = {6'd0, sqhi_q};
        mul_b = {15'd0, PWR_K};
      end
      ST_B1: begin
        mul_a = {9'd0, acc_f_q};
        mul_b = {10'd0, na};
      end
      ST_B2: begin
        mul_a = {9'd0, pf_q};
        mul_b = {11'd0, cfg_i.avg_alpha};
      end
      ST_B3: begin
        mul_a = {9'd0, acc_r_q};
        mul_b = {10'd0, na};
      end
      ST_B4: begin
        mul_a = {9'd0, pr_q};
        mul_b = {11'd0, cfg_i.avg_alpha};
      end
      ST_B5: begin
        mul_a = {10'd0, acc_s_q};
        mul_b = {10'd0, na};
      end
      ST_B6: begin
        mul_a = {10'd0, swr_q};
        mul_b = {11'd0, cfg_i.avg_alpha};
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  // Working registers: payload only, no reset.
  always_ff @(posedge clk_i) begin
    prod_q <= mul_a * mul_b;
    if (cmd_i.load_in) begin
      raw_f_q <= 16'(fwd_sample_i);
      raw_r_q <= 16'(rev_sample_i);
    end
    if (load_out) begin
      res_q.fwd_power  <= pf_q;
      res_q.rev_power  <= pr_q;
      res_q.swr_now    <= swr_q;
      res_q.peak_fwd   <= hold_f_q;
      res_q.peak_rev   <= hold_r_q;
      res_q.peak_swr   <= hold_s_q;
      res_q.mean_fwd   <= acc_f_q;
      res_q.mean_rev   <= acc_r_q;
      res_q.mean_swr   <= acc_s_q;
      res_q.rf_present <= pres_q;
    end
    case (cmd_i.step)
      ST_SCR:  sf_q <= sf_clamp;
      ST_SCR2: sr_q <= sc_sat;
      ST_DROP: base_q <= base_d;
      ST_U:    u_q <= base_q + {2'd0, drop_c};
      ST_A: begin
        a_q <= a_rnd[40:16];
        if (cmd_i.ch) begin
          ar_q <= a_rnd[40:16];
        end else begin
          af_q <= a_rnd[40:16];
        end
      end
      ST_SQ: big_q <= a_q > CUR_LIMIT;
      ST_LO: sqhi_q <= prod_q[44:24];
      ST_HI: tmp_q <= prod_q[35:0];
      ST_PWR: begin
        if (cmd_i.ch) begin
          pr_q <= pwr_d;
        end else begin
          pf_q <= pwr_d;
        end
      end
      ST_SINIT: begin
        rem_q <= num;
        dsr_q <= {dif, 17'd0};
        quo_q <= '0;
        if (af_q == '0 || ar_q > af_q) begin
          skip_q <= 1'b1;
          swr_q  <= SWR_ONE;
        end else if (ar_q == af_q) begin
          skip_q <= 1'b1;
          swr_q  <= SWR_MAX;
        end else begin
          skip_q <= 1'b0;
        end
      end
      ST_SCHK: begin
        // A quotient of 2^18 or more saturates without dividing.
        if (!skip_q && ({6'd0, rem_q} >= {dsr_q, 1'b0})) begin
          skip_q <= 1'b1;
          swr_q  <= SWR_MAX;
        end
      end
      ST_SDIV: begin
        if (!skip_q) begin
          if ({5'd0, rem_q} >= dsr_q) begin
            rem_q <= rem_q - dsr_q[36:0];
            quo_q <= {quo_q[QBITS-2:0], 1'b1};
          end else begin
            quo_q <= {quo_q[QBITS-2:0], 1'b0};
          end
          dsr_q <= {1'b0, dsr_q[41:1]};
        end
      end
      ST_SFIN: begin
        if (!skip_q) begin
          swr_q <= quo_c;
        end
      end
      ST_HCTL: begin
        pres_q <= pres_d;
        mv_q   <= moved;
      end
      ST_B2, ST_B4, ST_B6: tmp_q <= prod_q[35:0];
      default: begin
      end
    endcase
  end

  // History and output handshake state, cleared by reset.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
      hold_f_q  <= '0;
      hold_r_q  <= '0;
      hold_s_q  <= SWR_ONE;
      acc_f_q   <= '0;
      acc_r_q   <= '0;
      acc_s_q   <= SWR_ONE;
      prev_f_q  <= '0;
      prev_r_q  <= '0;
      off_q     <= '0;
    end else begin
      if (load_out) begin
        out_vld_q <= 1'b1;
      end else if (out_ready_i) begin
        out_vld_q <= 1'b0;
      end
      case (cmd_i.step)
        ST_HCTL: begin
          if (clr) begin
            hold_f_q <= '0;
            hold_r_q <= '0;
            hold_s_q <= SWR_ONE;
            acc_f_q  <= '0;
            acc_r_q  <= '0;
            acc_s_q  <= SWR_ONE;
          end
          off_q <= off_step;
        end
        ST_B3: begin
          if (mv_q) begin
            acc_f_q <= bsum[33:16];
          end
        end
        ST_B5: begin
          if (mv_q) begin
            acc_r_q <= bsum[33:16];
          end
        end
        ST_B7: begin
          if (mv_q) begin
            acc_s_q  <= bsum[32:16];
            prev_f_q <= sf_q;
            prev_r_q <= sr_q;
            if (pf_q > hold_f_q) begin
              hold_f_q <= pf_q;
            end
            if (pr_q > hold_r_q) begin
              hold_r_q <= pr_q;
            end
            if (swr_q > hold_s_q) begin
              hold_s_q <= swr_q;
            end
          end
          if (off_q > cfg_i.off_timeout) begin
            off_q <= OFF_PARK;
          end
        end
        default: begin
        end
      endcase
    end
  end

  assign out_valid_o = out_vld_q;
  assign res_o       = res_q;

endmodule

`default_nettype wire

@@ hdl/rf_power_swr_meter.sv @@
// Top level of the RF forward/reverse power and SWR meter.
// Depends on swrm_pkg, swrm_in_if, swrm_out_if, swrm_ctrl and swrm_dp.
`default_nettype none

// Each request on the sample channel carries one forward and one reverse detector
// reading and produces exactly one result: both powers in milliwatts, the present
// SWR in Q7.10, the held peaks, the exponential averages and an RF-present flag.
// A request skips the SWR division, and so finishes sooner, when no division is
// needed: zero forward current, a reflection ratio of unity or above, or a
// quotient so large that the SWR saturates. The time a request takes is set by
// the sequence of steps through the single shared 27x27 multiplier (two scalings,
// five products per channel, six for the averages) and by the restoring SWR
// divider, which produces one of its eighteen quotient bits per cycle. The
// result sits in an output register; the following request is taken while it
// waits, and only the final load of the next result waits for the earlier one
// to be collected. Peaks and averages move only when a scaled sample changes
// by more than the change threshold, and they are cleared when RF returns after
// the off timeout. Configuration registers are written through cfg_we_i,
// cfg_index_i and cfg_data_i, and should only be written while no request is
// in flight.

module rf_power_swr_meter import swrm_pkg::*; #(
  parameter int unsigned ADC_BITS = 10
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  swrm_in_if.sink               smp,
  swrm_out_if.source            res
);

  cfg_t cfg_q;
  cmd_t cmd;
  sts_t sts;
  res_t res_d;

  // Configuration register file; an index beyond the list is ignored.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.adc_scale           <= 16'd2260;
      cfg_q.coupler_gain        <= 16'd12048;
      cfg_q.diode_drop_cap      <= 10'd256;
      cfg_q.detect_threshold_mw <= 18'd200;
      cfg_q.change_threshold    <= 10'd48;
      cfg_q.avg_alpha           <= 16'd3277;
      cfg_q.off_timeout         <= 14'd10000;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        CFG_ADC_SCALE:        cfg_q.adc_scale           <= cfg_data_i[15:0];
        CFG_COUPLER_GAIN:     cfg_q.coupler_gain        <= cfg_data_i[15:0];
        CFG_DIODE_DROP_CAP:   cfg_q.diode_drop_cap      <= cfg_data_i[9:0];
        CFG_DETECT_THRESHOLD: cfg_q.detect_threshold_mw <= cfg_data_i[17:0];
        CFG_CHANGE_THRESHOLD: cfg_q.change_threshold    <= cfg_data_i[9:0];
        CFG_AVG_ALPHA:        cfg_q.avg_alpha           <= cfg_data_i[15:0];
        CFG_OFF_TIMEOUT:      cfg_q.off_timeout         <= cfg_data_i[13:0];
        default: begin
        end
      endcase
    end
  end

  swrm_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (smp.valid),
    .in_ready_o (smp.ready),
    .cmd_o      (cmd),
    .sts_i      (sts)
  );

  swrm_dp #(
    .ADC_BITS (ADC_BITS)
  ) u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg_q),
    .cmd_i        (cmd),
    .sts_o        (sts),
    .fwd_sample_i (smp.fwd_sample),
    .rev_sample_i (smp.rev_sample),
    .out_ready_i  (res.ready),
    .out_valid_o  (res.valid),
    .res_o        (res_d)
  );

  assign res.fwd_power  = res_d.fwd_power;
  assign res.rev_power  = res_d.rev_power;
  assign res.swr_now    = res_d.swr_now;
  assign res.peak_fwd   = res_d.peak_fwd;
  assign res.peak_rev   = res_d.peak_rev;
  assign res.peak_swr   = res_d.peak_swr;
  assign res.mean_fwd   = res_d.mean_fwd;
  assign res.mean_rev   = res_d.mean_rev;
  assign res.mean_swr   = res_d.mean_swr;
  assign res.rf_present = res_d.rf_present;

endmodule

`default_nettype wire

@@ hdl/swrm_chk.sv @@
// Port-level checks for the meter, bound to the top level.
// Depends on swrm_pkg and on rf_power_swr_meter for the bind.
`default_nettype none

module swrm_chk import swrm_pkg::*; (
  input logic             clk_i,
  input logic             rst_ni,
  input logic             in_valid_i,
  input logic             in_ready_i,
  input logic             out_valid_i,
  input logic             out_ready_i,
  input logic [PWR_W-1:0] fwd_power_i,
  input logic [SWR_W-1:0] swr_now_i,
  input logic [SWR_W-1:0] peak_swr_i,
  input logic             rf_present_i
);

  // A stalled result stays offered.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i)
    else $error("result withdrawn while stalled");

  // The meter works on one request at a time.
  a_one_req: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i |=> !in_ready_i)
    else $error("request taken while another is in work");

  a_swr_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> (swr_now_i >= SWR_ONE) && (swr_now_i <= SWR_MAX) &&
                    (peak_swr_i >= SWR_ONE) && (peak_swr_i <= SWR_MAX))
    else $error("SWR outside 1 to 99.9");

  a_present_power: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && rf_present_i |-> fwd_power_i != '0)
    else $error("RF present with zero forward power");

endmodule

bind rf_power_swr_meter swrm_chk u_swrm_chk (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_valid_i   (smp.valid),
  .in_ready_i   (smp.ready),
  .out_valid_i  (res.valid),
  .out_ready_i  (res.ready),
  .fwd_power_i  (res.fwd_power),
  .swr_now_i    (res.swr_now),
  .peak_swr_i   (res.peak_swr),
  .rf_present_i (res.rf_present)
);

`default_nettype wire
